// ----- hdl/gradient_noise_2d_assert.svh -----
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH
// Concurrent assertion helpers sampled on the block clock.
`ifndef ASSERT_OFF
`define GN2D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gradient_noise_2d assertion failed");
`define GN2D_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("gradient_noise_2d assertion failed");
`else
`define GN2D_ASSERT(lbl, prop)
`define GN2D_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/gn2d_pkg.sv -----
`default_nettype none
package gn2d_pkg;
  localparam int FRAC_BITS   = 16;
  localparam int SCALE_BITS  = 20;
  localparam int IDX_BITS    = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int LATENCY     = 7;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 20'd4096;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;
  localparam logic [1:0] GRAD_PP = 2'd0;
  localparam logic [1:0] GRAD_NP = 2'd1;
  localparam logic [1:0] GRAD_NN = 2'd2;
  localparam logic [1:0] GRAD_PN = 2'd3;

  typedef logic [IDX_BITS-1:0] byte_t;

  function automatic logic signed [17:0] grad_dot(input logic [1:0] h,
                                                  input logic signed [17:0] dx,
                                                  input logic signed [17:0] dy);
    logic signed [17:0] r;
    case (h)
      GRAD_PP: r = dx + dy;
      GRAD_NP: r = dy - dx;
      GRAD_NN: r = -dx - dy;
      GRAD_PN: r = dx - dy;
      default: r = dx + dy;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/gradient_noise_2d.sv -----
// Throughput: one request per cycle; busy stays low, loads and evaluations mix freely.
// The rate is set by the seven-stage pipeline, with the table reads in stages two and three.
// Reset clears the valid bits and loads scale_q with 4096; table contents stay
// undefined until written.
`default_nettype none
`include "gradient_noise_2d_assert.svh"
module gradient_noise_2d #(
  parameter int COORD_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire                         mode_i,
  input  wire  gn2d_pkg::byte_t       table_index_i,
  input  wire  gn2d_pkg::byte_t       table_value_i,
  input  wire  [COORD_BITS-1:0]       grid_x_i,
  input  wire  [COORD_BITS-1:0]       grid_y_i,
  input  wire                         cfg_we_i,
  input  wire  [gn2d_pkg::SCALE_BITS-1:0] cfg_wdata_i,
  output logic                        noise_valid_o,
  output logic [15:0]                 noise_value_o
);
  import gn2d_pkg::*;

  localparam int PB = COORD_BITS + SCALE_BITS;
  localparam int F  = FRAC_BITS;

  logic [SCALE_BITS-1:0] scale_q;
  logic [6:1] vld_q;
  logic [3:1] eval_q;
  logic [6:4] evl_q;

  byte_t tbl_a [TABLE_DEPTH];
  byte_t tbl_b [TABLE_DEPTH];
  byte_t tbl_c [TABLE_DEPTH];

  byte_t idx1_q, val1_q, idx2_q, val2_q, idx3_q, val3_q;
  logic [COORD_BITS-1:0] gx1_q, gy1_q;
  logic [PB-1:0] px2_q, py2_q;
  byte_t hx0_q, hx1_q, yi3_q;
  logic [F-1:0] fx3_q, fy3_q, fx4_q, fy4_q;
  logic [F-1:0] t2x_q, t2y_q, t3x_q, t3y_q;
  logic [20:0] inx_q, iny_q;
  byte_t hbl_q, htl_q, hbr_q, htr_q;
  logic [16:0] u5_q, v5_q, u6_q;
  logic signed [17:0] bl_q, tl_q, br_q, tr_q;
  logic signed [20:0] l0_q, l1_q;
  logic [15:0] out_q;
  logic out_vld_q;

  logic [31:0] sqx, sqy, cbx, cby;
  logic [20:0] inx_d, iny_d;
  logic [36:0] fdx, fdy;
  logic signed [17:0] fxs, fys, fxm, fym;
  logic signed [18:0] dl, dr;
  logic signed [36:0] pl, pr;
  logic signed [21:0] dn;
  logic signed [39:0] pn;
  logic signed [23:0] n_d, r_d;
  logic [15:0] out_d;
  byte_t xi2, yi2;

  assign busy = 1'b0;
  assign xi2 = px2_q[F+IDX_BITS-1:F];
  assign yi2 = py2_q[F+IDX_BITS-1:F];

  always_comb begin
    sqx = px2_q[F-1:0] * px2_q[F-1:0];
    sqy = py2_q[F-1:0] * py2_q[F-1:0];
    cbx = t2x_q * fx3_q;
    cby = t2y_q * fy3_q;
    inx_d = 21'(6 * {5'd0, t2x_q}) + 21'd655360 - 21'(15 * {5'd0, fx3_q});
    iny_d = 21'(6 * {5'd0, t2y_q}) + 21'd655360 - 21'(15 * {5'd0, fy3_q});
    fdx = {5'd0, t3x_q} * {16'd0, inx_q};
    fdy = {5'd0, t3y_q} * {16'd0, iny_q};
    fxs = $signed({2'b00, fx4_q});
    fys = $signed({2'b00, fy4_q});
    fxm = fxs - 18'sd65536;
    fym = fys - 18'sd65536;
    dl = 19'(tl_q) - 19'(bl_q);
    dr = 19'(tr_q) - 19'(br_q);
    pl = 37'($signed({1'b0, v5_q})) * 37'(dl);
    pr = 37'($signed({1'b0, v5_q})) * 37'(dr);
    dn = 22'(l1_q) - 22'(l0_q);
    pn = 40'($signed({1'b0, u6_q})) * 40'(dn);
    n_d = 24'(l0_q) + pn[39:16];
    r_d = n_d + 24'sd65536;
    if (r_d < 0) begin
      out_d = 16'd0;
    end else if (r_d[23:1] > 23'd65535) begin
      out_d = 16'hFFFF;
    end else begin
      out_d = r_d[16:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_RESET;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      vld_q     <= {vld_q[5:1], start & ~busy};
      out_vld_q <= vld_q[6] & evl_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    eval_q <= {eval_q[2:1], mode_i == MODE_EVAL};
    evl_q  <= {evl_q[5:4], eval_q[3]};
    idx1_q <= table_index_i;
    val1_q <= table_value_i;
    gx1_q  <= grid_x_i;
    gy1_q  <= grid_y_i;
    idx2_q <= idx1_q;
    val2_q <= val1_q;
    px2_q  <= {{SCALE_BITS{1'b0}}, gx1_q} * {{COORD_BITS{1'b0}}, scale_q};
    py2_q  <= {{SCALE_BITS{1'b0}}, gy1_q} * {{COORD_BITS{1'b0}}, scale_q};
    idx3_q <= idx2_q;
    val3_q <= val2_q;
    yi3_q  <= yi2;
    fx3_q  <= px2_q[F-1:0];
    fy3_q  <= py2_q[F-1:0];
    t2x_q  <= sqx[31:16];
    t2y_q  <= sqy[31:16];
    fx4_q  <= fx3_q;
    fy4_q  <= fy3_q;
    t3x_q  <= cbx[31:16];
    t3y_q  <= cby[31:16];
    inx_q  <= inx_d;
    iny_q  <= iny_d;
    u5_q   <= fdx[32:16];
    v5_q   <= fdy[32:16];
    bl_q   <= grad_dot(hbl_q[1:0], fxs, fys);
    tl_q   <= grad_dot(htl_q[1:0], fxs, fym);
    br_q   <= grad_dot(hbr_q[1:0], fxm, fys);
    tr_q   <= grad_dot(htr_q[1:0], fxm, fym);
    u6_q   <= u5_q;
    l0_q   <= 21'(bl_q) + pl[36:16];
    l1_q   <= 21'(br_q) + pr[36:16];
    out_q  <= out_d;
  end

  // Each copy of the table is written at the stage where it is read, so
  // requests see loads in request order.
  always_ff @(posedge clk_i) begin
    if (vld_q[2] && !eval_q[2]) begin
      tbl_a[idx2_q] <= val2_q;
    end
    hx0_q <= tbl_a[xi2];
    hx1_q <= tbl_a[byte_t'(xi2 + 8'd1)];
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[3] && !eval_q[3]) begin
      tbl_b[idx3_q] <= val3_q;
      tbl_c[idx3_q] <= val3_q;
    end
    hbl_q <= tbl_b[byte_t'(hx0_q + yi3_q)];
    htl_q <= tbl_b[byte_t'(hx0_q + yi3_q + 8'd1)];
    hbr_q <= tbl_c[byte_t'(hx1_q + yi3_q)];
    htr_q <= tbl_c[byte_t'(hx1_q + yi3_q + 8'd1)];
  end

  assign noise_valid_o = out_vld_q;
  assign noise_value_o = out_q;

  `GN2D_ASSERT(a_eval_gives_result, start && !busy && mode_i == MODE_EVAL |-> ##7 noise_valid_o)
  `GN2D_ASSERT(a_load_no_result, start && !busy && mode_i == MODE_LOAD |-> ##7 !noise_valid_o)
  `GN2D_ASSERT(a_result_source, noise_valid_o |-> $past(vld_q[6] && evl_q[6]))
  `GN2D_ASSERT_NEVER(a_idle_no_result, noise_valid_o && !$past(vld_q[6]))
endmodule
`default_nettype wire
